FILE: rtl/gval_pkg.sv
// Package: shared types, constants and opcodes for the goal velocity limiter.
package gval_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam int DATA_W = 32;
	localparam int IN_TDATA_W = 192;
	localparam int OUT_TDATA_W = 96;
	localparam int MODE_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED_ONE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_TWO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 3'd4;

	localparam logic [MODE_W-1:0] MODE_ONE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TWO = 2'd2;

	typedef enum logic [1:0] {
		OP_SQRT,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
	} alu_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQX,
		ST_SQY,
		ST_SQRT_D,
		ST_WAIT_D,
		ST_TGT_MUL,
		ST_TGT_DIV,
		ST_WAIT_T,
		ST_WX_MUL,
		ST_WX_DIV,
		ST_WAIT_WX,
		ST_WY_MUL,
		ST_WY_DIV,
		ST_WAIT_WY,
		ST_ACC,
		ST_AX,
		ST_AY,
		ST_AZ,
		ST_SQRT_A,
		ST_WAIT_A,
		ST_SC_MUL,
		ST_SC_DIV,
		ST_WAIT_SC,
		ST_UPDATE,
		ST_OUT
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		r = v[DATA_W-1:0];
		if (v[DATA_W] != v[DATA_W-1])
			r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction
endpackage

FILE: rtl/gval_alu.sv
// Iterative unit: 64-bit integer square root or 64/32 division, one bit per cycle.
module gval_alu (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gval_pkg::alu_ctl_t     ctl,
	input  logic [63:0]            num,
	input  logic [31:0]            den,
	output logic                   busy,
	output logic [63:0]            res
);
	import gval_pkg::*;

	logic [6:0]  cnt_q;
	op_t         op_q;
	logic [63:0] rem_q;
	logic [63:0] acc_q;
	logic [63:0] bit_q;
	logic [63:0] q_q;
	logic [31:0] den_q;
	logic [64:0] trial;
	logic [64:0] rsum;

	assign busy = (cnt_q != 7'd0);
	assign res = q_q;
	assign trial = {rem_q, acc_q[63]};
	assign rsum = {1'b0, q_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q <= OP_SQRT;
		end else if (ctl.start) begin
			op_q <= ctl.op;
			cnt_q <= (ctl.op == OP_DIV) ? 7'd64 : 7'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			den_q <= den;
			if (ctl.op == OP_DIV) begin
				rem_q <= '0;
				acc_q <= num;
				q_q <= '0;
			end else begin
				rem_q <= num;
				q_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
		end else if (busy) begin
			if (op_q == OP_DIV) begin
				acc_q <= {acc_q[62:0], 1'b0};
				if (trial >= {33'd0, den_q}) begin
					rem_q <= 64'(trial - {33'd0, den_q});
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					rem_q <= trial[63:0];
					q_q <= {q_q[62:0], 1'b0};
				end
			end else begin
				if ({1'b0, rem_q} >= rsum) begin
					rem_q <= 64'({1'b0, rem_q} - rsum);
					q_q <= (q_q >> 1) + bit_q;
				end else begin
					q_q <= q_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end
endmodule

FILE: rtl/gval_ctrl.sv
// Sequencer and datapath registers around the shared root/divide unit.
module gval_ctrl #(
	parameter int FRAC_BITS = gval_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gval_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gval_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                s_valid,
	output logic                                s_ready,
	input  logic [gval_pkg::IN_TDATA_W-1:0]     s_data,
	input  logic [gval_pkg::MODE_W-1:0]         s_mode,
	output logic                                m_valid,
	input  logic                                m_ready,
	output logic [gval_pkg::OUT_TDATA_W-1:0]    m_data
);
	import gval_pkg::*;

	localparam logic [CFG_W-1:0] RST_ONE = CFG_W'(64'd5 << FRAC_BITS);
	localparam logic [CFG_W-1:0] RST_TWO = CFG_W'(64'd15 << FRAC_BITS);
	localparam logic [CFG_W-1:0] RST_UNIT = CFG_W'(64'd1 << FRAC_BITS);

	state_t state_q, state_d;
	alu_ctl_t actl;
	logic alu_busy;
	logic [63:0] alu_res, alu_num;
	logic [31:0] alu_den;

	logic [CFG_W-1:0] spd1_q, spd2_q, zlim_q, rad_q, acc_q;
	logic [IN_TDATA_W-1:0] in_q;
	logic [MODE_W-1:0] mode_q;
	logic signed [31:0] dx_q, dy_q, dz_q, wx_q, wy_q, wz_q;
	logic signed [31:0] hx_q, hy_q, hz_q;
	logic [31:0] d_q, tgt_q, am_q;
	logic [65:0] ssum_q;
	logic [63:0] prod_q;
	logic [1:0] idx_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic signed [31:0] cur_sgn;
	logic [31:0] cur_mag;
	logic [31:0] vmax;
	logic signed [32:0] dz_mag;

	gval_alu u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(actl), .num(alu_num), .den(alu_den),
		.busy(alu_busy), .res(alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd1_q <= RST_ONE;
			spd2_q <= RST_TWO;
			zlim_q <= RST_ONE;
			rad_q <= RST_ONE;
			acc_q <= RST_UNIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_ONE: spd1_q <= cfg_data;
				REG_SPEED_TWO: spd2_q <= cfg_data;
				REG_Z_LIMIT: zlim_q <= cfg_data;
				REG_RADIUS: rad_q <= cfg_data;
				REG_ACCEL: acc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vmax = (mode_q == MODE_ONE) ? {1'b0, spd1_q} : {1'b0, spd2_q};

	// component under work in the square, per-axis and shared scale steps
	always_comb begin
		unique case (idx_q)
			2'd0: cur_sgn = (state_q inside {ST_SQX, ST_WX_MUL, ST_WX_DIV, ST_WAIT_WX})
				? dx_q : wx_q;
			2'd1: cur_sgn = (state_q inside {ST_SQY, ST_WY_MUL, ST_WY_DIV, ST_WAIT_WY})
				? dy_q : wy_q;
			default: cur_sgn = wz_q;
		endcase
		cur_mag = cur_sgn[31] ? 32'(-cur_sgn) : cur_sgn;
	end

	always_comb begin
		mul_a = cur_mag;
		mul_b = cur_mag;
		priority case (state_q)
			ST_TGT_MUL: begin mul_a = vmax; mul_b = d_q; end
			ST_WX_MUL, ST_WY_MUL: mul_b = tgt_q;
			ST_SC_MUL: mul_b = {1'b0, acc_q};
			default: ;
		endcase
	end
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	always_comb begin
		actl.start = 1'b0;
		actl.op = OP_DIV;
		alu_num = prod_q;
		alu_den = d_q;
		priority case (state_q)
			ST_SQRT_D, ST_SQRT_A: begin
				actl.start = 1'b1;
				actl.op = OP_SQRT;
				alu_num = 64'(ssum_q + {2'b0, prod_q});
			end
			ST_TGT_DIV: begin actl.start = 1'b1; alu_den = {1'b0, rad_q}; end
			ST_WX_DIV, ST_WY_DIV: actl.start = 1'b1;
			ST_SC_DIV: begin actl.start = 1'b1; alu_den = am_q; end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_valid && (s_mode == MODE_ONE || s_mode == MODE_TWO))
				state_d = ST_DIFF;
			ST_DIFF: state_d = ST_SQX;
			ST_SQX: state_d = ST_SQY;
			ST_SQY: state_d = ST_SQRT_D;
			ST_SQRT_D: state_d = ST_WAIT_D;
			ST_WAIT_D: if (!alu_busy)
				state_d = (alu_res[31:0] < {1'b0, rad_q}) ? ST_TGT_MUL : ST_WX_MUL;
			ST_TGT_MUL: state_d = ST_TGT_DIV;
			ST_TGT_DIV: state_d = ST_WAIT_T;
			ST_WAIT_T: if (!alu_busy) state_d = ST_WX_MUL;
			ST_WX_MUL: state_d = (d_q == 32'd0) ? ST_ACC : ST_WX_DIV;
			ST_WX_DIV: state_d = ST_WAIT_WX;
			ST_WAIT_WX: if (!alu_busy) state_d = ST_WY_MUL;
			ST_WY_MUL: state_d = ST_WY_DIV;
			ST_WY_DIV: state_d = ST_WAIT_WY;
			ST_WAIT_WY: if (!alu_busy) state_d = ST_ACC;
			ST_ACC: state_d = ST_AX;
			ST_AX: state_d = ST_AY;
			ST_AY: state_d = ST_AZ;
			ST_AZ: state_d = ST_SQRT_A;
			ST_SQRT_A: state_d = ST_WAIT_A;
			ST_WAIT_A: if (!alu_busy)
				state_d = (alu_res[31:0] > {1'b0, acc_q}) ? ST_SC_MUL : ST_UPDATE;
			ST_SC_MUL: state_d = ST_SC_DIV;
			ST_SC_DIV: state_d = ST_WAIT_SC;
			ST_WAIT_SC: if (!alu_busy) state_d = (idx_q == 2'd2) ? ST_UPDATE : ST_SC_MUL;
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT: if (m_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = (state_q == ST_OUT);
	assign m_data = {hz_q, hy_q, hx_q};
	assign dz_mag = {1'b0, (dz_q[31] ? 32'(-dz_q) : dz_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hx_q <= '0;
			hy_q <= '0;
			hz_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPDATE) begin
				hx_q <= sat32({hx_q[31], hx_q} + {wx_q[31], wx_q});
				hy_q <= sat32({hy_q[31], hy_q} + {wy_q[31], wy_q});
				hz_q <= sat32({hz_q[31], hz_q} + {wz_q[31], wz_q});
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				in_q <= s_data;
				mode_q <= s_mode;
				idx_q <= 2'd0;
			end
			ST_DIFF: begin
				dx_q <= sat32({in_q[31], in_q[31:0]} - {in_q[127], in_q[127:96]});
				dy_q <= sat32({in_q[63], in_q[63:32]} - {in_q[159], in_q[159:128]});
				dz_q <= sat32({in_q[95], in_q[95:64]} - {in_q[191], in_q[191:160]});
				ssum_q <= '0;
			end
			ST_SQX: idx_q <= 2'd1;
			ST_SQY: begin
				ssum_q <= {2'b0, prod_q};
				idx_q <= 2'd0;
			end
			ST_SQRT_D: ssum_q <= ssum_q + {2'b0, prod_q};
			ST_WAIT_D: if (!alu_busy) begin
				d_q <= alu_res[31:0];
				tgt_q <= vmax;
				wx_q <= '0;
				wy_q <= '0;
				idx_q <= 2'd0;
			end
			ST_WAIT_T: if (!alu_busy) tgt_q <= alu_res[31:0];
			ST_WAIT_WX: if (!alu_busy) begin
				wx_q <= dx_q[31] ? 32'(-alu_res[31:0]) : alu_res[31:0];
				idx_q <= 2'd1;
			end
			ST_WAIT_WY: if (!alu_busy)
				wy_q <= dy_q[31] ? 32'(-alu_res[31:0]) : alu_res[31:0];
			ST_ACC: begin
				if (dz_mag > {2'b0, zlim_q})
					wz_q <= dz_q[31] ? 32'(-{1'b0, zlim_q}) : {1'b0, zlim_q};
				else
					wz_q <= dz_q;
				wx_q <= sat32({wx_q[31], wx_q} - {hx_q[31], hx_q});
				wy_q <= sat32({wy_q[31], wy_q} - {hy_q[31], hy_q});
				idx_q <= 2'd0;
			end
			ST_AX: begin
				wz_q <= sat32({wz_q[31], wz_q} - {hz_q[31], hz_q});
				idx_q <= 2'd1;
			end
			ST_AY: begin
				ssum_q <= {2'b0, prod_q};
				idx_q <= 2'd2;
			end
			ST_AZ: ssum_q <= ssum_q + {2'b0, prod_q};
			ST_SQRT_A: begin
				ssum_q <= ssum_q + {2'b0, prod_q};
				idx_q <= 2'd0;
			end
			ST_WAIT_A: if (!alu_busy) am_q <= alu_res[31:0];
			ST_WAIT_SC: if (!alu_busy) begin
				unique case (idx_q)
					2'd0: wx_q <= wx_q[31] ? 32'(-alu_res[31:0]) : alu_res[31:0];
					2'd1: wy_q <= wy_q[31] ? 32'(-alu_res[31:0]) : alu_res[31:0];
					default: wz_q <= wz_q[31] ? 32'(-alu_res[31:0]) : alu_res[31:0];
				endcase
				idx_q <= idx_q + 2'd1;
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/goal_velocity_accel_limiter_unit.sv
// Top level of the goal velocity limiter with acceleration clamp.
// Usage:
//   s_axis: one transfer per control tick; tuser carries mode, tdata the
//   goal and current position. Mode 0 or 3 is consumed with no result.
//   m_axis: one transfer per tick in mode 1 or 2 with the new velocity.
//   cfg: write enable, index and data; write only while idle.
// Sequence: after the input transfer the block runs two square roots and up
//   to six divisions on the one shared unit, each started from its own start
//   state and picked up in a wait state, before m_axis_tvalid rises. The short
//   case is zero distance and zero radius with no acceleration clamp, the long
//   one a slow-down target plus a clamped change. s_axis_tready returns
//   the cycle after the output transfer; no new tick is taken before then.
// Reset clears the held velocity and loads default limits.
// Stalls: the result holds on m_axis_tdata until m_axis_tready.
module goal_velocity_accel_limiter_unit #(
	parameter int FRAC_BITS = gval_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gval_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gval_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// goal_x, goal_y, goal_z, pos_x, pos_y, pos_z
	input  logic [gval_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// mode
	input  logic [gval_pkg::MODE_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// vel_x, vel_y, vel_z
	output logic [gval_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import gval_pkg::*;

	gval_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_data(s_axis_tdata), .s_mode(s_axis_tuser),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata)
	);
endmodule

FILE: rtl/gval_checker.sv
// Port checker for the goal velocity limiter, bound to the top level.
module gval_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> s_axis_tready)
		else $error("not ready after transfer");
endmodule

bind goal_velocity_accel_limiter_unit gval_checker u_chk (.*);
